>>> sv/jcdp_pkg.sv
// Shared constants and types of the windowed jump-cost dynamic program.
`timescale 1ns / 1ps

package jcdp_pkg;

  // Depth of the history window: the most stones that one jump may span.
  localparam int MAX_K = 16;

  // Address width of the window memory and width of the stone counter.
  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);

  // Common width for comparing the jump limit register with the window depth.
  localparam int LIMIT_W = 5;
  localparam int SW = (CW > LIMIT_W) ? CW : LIMIT_W;

  localparam int HEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int ENTRY_W  = HEIGHT_W + COST_W;

  localparam logic [COST_W-1:0]  COST_MAX         = '1;
  localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET = LIMIT_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

>>> sv/jcdp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module jcdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/jcdp_step_unit.sv
// Shared step unit: absolute height difference, saturating add and running minimum.
`timescale 1ns / 1ps

module jcdp_step_unit (
  input  logic [jcdp_pkg::HEIGHT_W-1:0] height,
  input  logic [jcdp_pkg::HEIGHT_W-1:0] prev_height,
  input  logic [jcdp_pkg::COST_W-1:0]   prev_cost,
  input  logic [jcdp_pkg::COST_W-1:0]   best_in,
  output logic [jcdp_pkg::COST_W-1:0]   best_out
);

  logic [jcdp_pkg::HEIGHT_W-1:0] diff;
  logic [jcdp_pkg::COST_W:0]     sum;
  logic [jcdp_pkg::COST_W-1:0]   cand;

  always_comb begin
    diff = (height >= prev_height) ? (height - prev_height) : (prev_height - height);
    sum  = {1'b0, prev_cost} + (jcdp_pkg::COST_W + 1)'(diff);
    // A carry out of the top bit means the cost has run past its range.
    cand = sum[jcdp_pkg::COST_W] ? jcdp_pkg::COST_MAX : sum[jcdp_pkg::COST_W-1:0];
    best_out = (cand < best_in) ? cand : best_in;
  end

endmodule

>>> sv/windowed_jump_cost_dp.sv
// Top level of the windowed jump-cost dynamic program (frog jump with up to k stones).
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_*       in         tdata[15:0] height, tuser first (starts a new path)
// m_*       out        tdata[31:0] path_cost
// cfg_*     in         cfg_wr_data[4:0] jump_limit, written when cfg_wr_en is high
//
// Span is the smaller of the effective jump limit and the stones held for the path. The scan
// reads span entries from the window; once the last read is folded into the running minimum,
// the sequencer leaves the scan, writes the result in the final state and returns to idle
// before the next stone can be accepted. A stone with a span of zero goes straight from idle
// to the final state. The window memory gives one entry per cycle during the scan to the
// single shared step unit.
// Reset clears the sequencer, the stone count, the write pointer and the output valid, and
// sets the jump limit to two. The window memory is left as it is, since only entries
// written on the current path are ever read.
// The finished cost waits in the final state until the output register is free, and
// s_tready is high only while the sequencer is idle and out of reset.

module windowed_jump_cost_dp (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] height
  input  logic        s_tuser,   // [0] first
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] path_cost
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  jcdp_pkg::state_t state, state_next;

  logic [jcdp_pkg::LIMIT_W-1:0]  jump_limit;
  logic [jcdp_pkg::CW-1:0]       seen;
  logic [jcdp_pkg::AW-1:0]       wr_ptr;
  logic [jcdp_pkg::AW-1:0]       rd_addr;
  logic [jcdp_pkg::CW-1:0]       span;
  logic [jcdp_pkg::CW-1:0]       issued;
  logic                          rd_pending;
  logic [jcdp_pkg::HEIGHT_W-1:0] height;
  logic [jcdp_pkg::COST_W-1:0]   best;

  logic                          accept;
  logic                          issue;
  logic                          out_free;
  logic                          finish;
  logic [jcdp_pkg::CW-1:0]       seen_eff;
  logic [jcdp_pkg::SW-1:0]       limit_eff;
  logic [jcdp_pkg::CW-1:0]       span_new;
  logic [jcdp_pkg::AW-1:0]       newest;
  logic [jcdp_pkg::ENTRY_W-1:0]  rdata;
  logic [jcdp_pkg::COST_W-1:0]   best_step;

  // Step back one place in the circular window, wrapping below zero.
  function automatic logic [jcdp_pkg::AW-1:0] addr_dec(input logic [jcdp_pkg::AW-1:0] a);
    if (a == '0) begin
      return jcdp_pkg::AW'(jcdp_pkg::MAX_K - 1);
    end
    return a - jcdp_pkg::AW'(1);
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign issue    = (state == jcdp_pkg::ST_SCAN) && (issued != span);
  assign finish   = (state == jcdp_pkg::ST_FINISH) && out_free;
  assign newest   = addr_dec(wr_ptr);

  // A first stone, or one with no history, sees an empty window. A limit of zero acts as
  // one, and a limit beyond the window depth is held to the depth.
  always_comb begin
    seen_eff = s_tuser ? '0 : seen;
    if (jump_limit == '0) begin
      limit_eff = jcdp_pkg::SW'(1);
    end else if (jcdp_pkg::SW'(jump_limit) > jcdp_pkg::SW'(jcdp_pkg::MAX_K)) begin
      limit_eff = jcdp_pkg::SW'(jcdp_pkg::MAX_K);
    end else begin
      limit_eff = jcdp_pkg::SW'(jump_limit);
    end
    span_new = (limit_eff < jcdp_pkg::SW'(seen_eff)) ? jcdp_pkg::CW'(limit_eff) : seen_eff;
  end

  // Sequencer: next state and the ready output.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      jcdp_pkg::ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = (span_new == '0) ? jcdp_pkg::ST_FINISH : jcdp_pkg::ST_SCAN;
        end
      end
      jcdp_pkg::ST_SCAN: begin
        if ((issued == span) && !rd_pending) begin
          state_next = jcdp_pkg::ST_FINISH;
        end
      end
      jcdp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = jcdp_pkg::ST_IDLE;
        end
      end
      default: state_next = jcdp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jcdp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit <= jcdp_pkg::JUMP_LIMIT_RESET;
      seen       <= '0;
      wr_ptr     <= '0;
      issued     <= '0;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        jump_limit <= cfg_wr_data;
      end
      if (accept) begin
        seen   <= seen_eff;
        issued <= '0;
      end else if (issue) begin
        issued <= issued + jcdp_pkg::CW'(1);
      end
      rd_pending <= issue;
      if (finish) begin
        wr_ptr <= (wr_ptr == jcdp_pkg::AW'(jcdp_pkg::MAX_K - 1)) ? '0
                                                                 : wr_ptr + jcdp_pkg::AW'(1);
        if (seen != jcdp_pkg::CW'(jcdp_pkg::MAX_K)) begin
          seen <= seen + jcdp_pkg::CW'(1);
        end
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers. The running minimum starts at the top of the cost range, or at
  // zero when the window is empty so that the first stone of a path costs nothing.
  always_ff @(posedge clk) begin
    if (accept) begin
      height  <= s_tdata;
      span    <= span_new;
      rd_addr <= newest;
      best    <= (span_new == '0) ? '0 : jcdp_pkg::COST_MAX;
    end else begin
      if (issue) begin
        rd_addr <= addr_dec(rd_addr);
      end
      if (rd_pending) begin
        best <= best_step;
      end
    end
    if (finish) begin
      m_tdata <= best;
    end
  end

  // Window memory: each entry holds a height in the top bits and its cost below.
  jcdp_ram #(
    .WIDTH (jcdp_pkg::ENTRY_W),
    .DEPTH (jcdp_pkg::MAX_K)
  ) u_window (
    .clk   (clk),
    .we    (finish),
    .waddr (wr_ptr),
    .wdata ({height, best}),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  jcdp_step_unit u_step (
    .height      (height),
    .prev_height (rdata[jcdp_pkg::ENTRY_W-1:jcdp_pkg::COST_W]),
    .prev_cost   (rdata[jcdp_pkg::COST_W-1:0]),
    .best_in     (best),
    .best_out    (best_step)
  );

  // The scan never reads more entries than the span set at acceptance.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == jcdp_pkg::ST_SCAN) |-> (issued <= span))
    else $error("window scan ran past its span");

  // The stone count never exceeds the window depth.
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= jcdp_pkg::CW'(jcdp_pkg::MAX_K))
    else $error("stone count exceeds window depth");

  // The first stone of a path goes straight to the final state with a zero cost.
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> ((state == jcdp_pkg::ST_FINISH) && (best == '0)))
    else $error("first stone of a path did not cost zero");

  // The result register takes the finished cost at the edge that writes the window entry.
  a_load_after_write: assert property (@(posedge clk) disable iff (rst)
    finish |=> (m_tvalid && (m_tdata == $past(best))))
    else $error("result register missed the finished cost");

  // No read is outstanding when the sequencer leaves the scan.
  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    ((state == jcdp_pkg::ST_SCAN) && (state_next == jcdp_pkg::ST_FINISH)) |-> !rd_pending)
    else $error("scan ended with a read in flight");

endmodule

>>> verif/tb_windowed_jump_cost_dp.sv
// Self-checking testbench for the windowed jump-cost dynamic program.
`timescale 1ns / 1ps

module tb_windowed_jump_cost_dp;

  // Height patterns used to fill a random path.
  typedef enum int unsigned {
    HM_RANDOM,
    HM_NEAR,
    HM_EXTREME,
    HM_RAMP
  } height_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [jcdp_pkg::HEIGHT_W-1:0] s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [jcdp_pkg::COST_W-1:0]   m_tdata;
  logic                          cfg_wr_en;
  logic [jcdp_pkg::LIMIT_W-1:0]  cfg_wr_data;

  // Private copy of the block's state, advanced once per accepted stone.
  logic [jcdp_pkg::HEIGHT_W-1:0] win_height [jcdp_pkg::MAX_K];
  logic [jcdp_pkg::COST_W-1:0]   win_cost   [jcdp_pkg::MAX_K];
  int unsigned                   seen_count;
  logic [jcdp_pkg::LIMIT_W-1:0]  limit_reg;

  logic [jcdp_pkg::COST_W-1:0]   cost_q [$];
  int unsigned                   fail_count;
  int unsigned                   stones_sent;
  bit                            calm;

  windowed_jump_cost_dp dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Least cost to reach a stone, with the history window updated afterwards.
  function automatic logic [jcdp_pkg::COST_W-1:0] next_path_cost(
      input logic [jcdp_pkg::HEIGHT_W-1:0] h, input logic new_path);
    int                            span;
    logic [jcdp_pkg::COST_W:0]     best;
    logic [jcdp_pkg::COST_W:0]     cand;
    logic [jcdp_pkg::HEIGHT_W-1:0] diff;
    logic [jcdp_pkg::COST_W-1:0]   cost;
    if (new_path) seen_count = 0;
    if (seen_count == 0) begin
      cost = '0;
    end else begin
      // A limit of zero acts as one; anything beyond the window depth is clipped.
      span = int'(limit_reg);
      if (span < 1) span = 1;
      if (span > jcdp_pkg::MAX_K) span = jcdp_pkg::MAX_K;
      if (span > int'(seen_count)) span = int'(seen_count);
      best = {1'b0, jcdp_pkg::COST_MAX};
      for (int i = 0; i < span; i++) begin
        diff = (h >= win_height[i]) ? h - win_height[i] : win_height[i] - h;
        cand = {1'b0, win_cost[i]}
             + {{(jcdp_pkg::COST_W + 1 - jcdp_pkg::HEIGHT_W){1'b0}}, diff};
        if (cand > {1'b0, jcdp_pkg::COST_MAX}) cand = {1'b0, jcdp_pkg::COST_MAX};
        if (cand < best) best = cand;
      end
      cost = best[jcdp_pkg::COST_W-1:0];
    end
    for (int i = jcdp_pkg::MAX_K - 1; i > 0; i--) begin
      win_height[i] = win_height[i-1];
      win_cost[i]   = win_cost[i-1];
    end
    win_height[0] = h;
    win_cost[0]   = cost;
    if (seen_count < jcdp_pkg::MAX_K) seen_count++;
    return cost;
  endfunction

  // Offers one stone, holding it until the block takes the beat. Called at a clock edge.
  task automatic send_stone(input logic [jcdp_pkg::HEIGHT_W-1:0] h, input logic new_path);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    s_tuser  <= new_path;
    do @(posedge clk); while (!s_tready);
    cost_q.push_back(next_path_cost(h, new_path));
    stones_sent++;
  endtask

  // The register is only touched once every outstanding cost has come back.
  task automatic write_jump_limit(input logic [jcdp_pkg::LIMIT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (jcdp_pkg::MAX_K + 3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_reg = value;
  endtask

  task automatic send_path(input int unsigned len);
    height_mode_t                  mode;
    logic [jcdp_pkg::HEIGHT_W-1:0] base;
    logic [jcdp_pkg::HEIGHT_W-1:0] h;
    mode = height_mode_t'($urandom_range(3));
    base = jcdp_pkg::HEIGHT_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        HM_RANDOM:  h = jcdp_pkg::HEIGHT_W'($urandom);
        HM_NEAR:    h = base + jcdp_pkg::HEIGHT_W'($urandom_range(64))
                        - jcdp_pkg::HEIGHT_W'(32);
        HM_EXTREME: h = $urandom_range(1) ? '1 : '0;
        default:    h = base + jcdp_pkg::HEIGHT_W'(i * 997);
      endcase
      send_stone(h, i == 0);
    end
  endtask

  // Straight after reset a stone without the path flag still costs nothing.
  task automatic test_no_history();
    send_stone(16'd1234, 1'b0);
    send_stone(16'd1000, 1'b0);
    send_stone(16'd1500, 1'b0);
  endtask

  // Lowest and highest heights, under the reset value of the jump limit.
  task automatic test_height_extremes();
    send_stone('0, 1'b1);
    send_stone('1, 1'b0);
    send_stone('0, 1'b0);
    send_stone('1, 1'b0);
    send_stone(16'h8000, 1'b0);
  endtask

  // A zero limit behaves as one, and a limit past the window depth is clipped.
  task automatic test_limit_bounds();
    write_jump_limit('0);
    send_stone(16'd10, 1'b1);
    send_stone(16'd50000, 1'b0);
    send_stone(16'd10, 1'b0);
    send_stone(16'd20, 1'b0);
    write_jump_limit('1);
    send_path(18);
  endtask

  // Paths of random length and shape under a sequence of jump limits.
  task automatic test_random_paths();
    logic [jcdp_pkg::LIMIT_W-1:0] phase_limits [12];
    int unsigned                  goal;
    int unsigned                  roll;
    int unsigned                  len;
    phase_limits = '{jcdp_pkg::LIMIT_W'(1), jcdp_pkg::LIMIT_W'(3), jcdp_pkg::LIMIT_W'(16),
                     jcdp_pkg::LIMIT_W'(0), jcdp_pkg::LIMIT_W'(31), jcdp_pkg::LIMIT_W'(8),
                     jcdp_pkg::LIMIT_W'(2), jcdp_pkg::LIMIT_W'(17), jcdp_pkg::LIMIT_W'(5),
                     jcdp_pkg::LIMIT_W'(12), jcdp_pkg::LIMIT_W'($urandom),
                     jcdp_pkg::LIMIT_W'($urandom_range(1, 16))};
    for (int p = 0; p < 12; p++) begin
      write_jump_limit(phase_limits[p]);
      // One phase runs with neither side holding back.
      calm = (p == 4);
      goal = stones_sent + 75;
      while (stones_sent < goal) begin
        roll = $urandom_range(99);
        if (roll < 20) len = 1;
        else if (roll < 90) len = $urandom_range(2, 40);
        else len = $urandom_range(41, 80);
        send_path(len);
      end
    end
    calm = 1'b0;
  endtask

  // Result side: compare each accepted beat with the oldest predicted cost.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cost_q.size() == 0) begin
        fail_count++;
        $error("unexpected beat, path_cost %0d", m_tdata);
      end else if (m_tdata !== cost_q[0]) begin
        fail_count++;
        $error("path_cost mismatch: expected %0d, actual %0d", cost_q[0], m_tdata);
        void'(cost_q.pop_front());
      end else begin
        void'(cost_q.pop_front());
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 31);
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    m_tready    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    seen_count  = 0;
    limit_reg   = jcdp_pkg::JUMP_LIMIT_RESET;
    fail_count  = 0;
    stones_sent = 0;
    calm        = 1'b0;
    for (int i = 0; i < jcdp_pkg::MAX_K; i++) begin
      win_height[i] = '0;
      win_cost[i]   = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_history();
    test_height_extremes();
    test_limit_bounds();
    test_random_paths();

    s_tvalid <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (jcdp_pkg::MAX_K + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/jcdp_pkg.sv
sv/jcdp_ram.sv
sv/jcdp_step_unit.sv
sv/windowed_jump_cost_dp.sv
verif/tb_windowed_jump_cost_dp.sv
